/* rtl/core/mpal_pkg.sv */
// Package: shared types, sizes and command/status codes of the MAC pair allow-list
`timescale 1ns / 1ps
package mpal_pkg;

	// Table size and derived widths
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Fixed field widths
	localparam int CMD_W    = 3;
	localparam int MAC_W    = 48;
	localparam int DATE_W   = 27;
	localparam int HIT_W    = 7;
	localparam int STATUS_W = 2;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [MAC_W-1:0]    mac_t;
	typedef logic [DATE_W-1:0]   date_t;
	typedef logic [HIT_W-1:0]    hit_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;

	// Command codes
	localparam cmd_t CMD_BEGIN_REFRESH = 3'd0;
	localparam cmd_t CMD_ADD           = 3'd1;
	localparam cmd_t CMD_END_REFRESH   = 3'd2;
	localparam cmd_t CMD_DEV_LOOKUP    = 3'd3;
	localparam cmd_t CMD_AP_LOOKUP     = 3'd4;

	// Status codes
	localparam status_t ST_DONE     = 2'd0;
	localparam status_t ST_UPDATED  = 2'd1;
	localparam status_t ST_INSERTED = 2'd2;
	localparam status_t ST_FULL     = 2'd3;

	// Stored client MAC of all ones matches any client
	localparam mac_t MAC_ANY = '1;

	// One table entry as held in the entry memory
	typedef struct packed {
		mac_t  client;
		mac_t  ap;
		date_t expiry;
	} entry_t;

endpackage

/* rtl/core/mpal_req_if.sv */
// Interface: command channel into the MAC pair allow-list
`timescale 1ns / 1ps
interface mpal_req_if;
	import mpal_pkg::*;

	logic  valid;
	logic  ready;
	cmd_t  cmd;
	mac_t  ap_mac;
	mac_t  device_mac;
	date_t expiry_date;
	date_t today;

	modport source (output valid, cmd, ap_mac, device_mac, expiry_date, today, input ready);
	modport sink   (input valid, cmd, ap_mac, device_mac, expiry_date, today, output ready);
endinterface

/* rtl/core/mpal_rsp_if.sv */
// Interface: result channel out of the MAC pair allow-list
`timescale 1ns / 1ps
interface mpal_rsp_if;
	import mpal_pkg::*;

	logic    valid;
	logic    ready;
	hit_t    hit_index;
	status_t status;

	modport source (output valid, hit_index, status, input ready);
	modport sink   (input valid, hit_index, status, output ready);
endinterface

/* rtl/core/mac_pair_allow_list.sv */
// Top level: MAC pair allow-list table with scanning command sequencer
`timescale 1ns / 1ps
// One transaction on req carries one command; one result leaves on rsp for each. Begin refresh,
// end refresh and unknown commands go from acceptance straight to the result state. Add and both
// lookups walk the table in index order through a single registered read port of the entry
// memory, one entry per cycle, and end the scan on a decision or after the last entry. The next
// command is taken once the result has been loaded into the output register; a stalled result
// holds the next command back until the output register frees. Enable, seen and written marks
// are flip-flops cleared by reset, so the table needs no clearing pass after reset.
module mac_pair_allow_list (
	input  logic          clk,
	input  logic          arst_n,
	mpal_req_if.sink      req,
	mpal_rsp_if.source    rsp
);
	import mpal_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_RESULT = 2'd2;

	logic [1:0] state_q;

	// Captured command
	cmd_t  cmd_q;
	mac_t  ap_q;
	mac_t  dev_q;
	date_t exp_q;
	date_t today_q;

	// Per-entry marks
	logic [TABLE_DEPTH-1:0] en_q;
	logic [TABLE_DEPTH-1:0] seen_q;
	logic [TABLE_DEPTH-1:0] used_q;

	// Entry memory and scan pipeline
	entry_t mem [TABLE_DEPTH];
	cnt_t   rd_idx_q;
	logic   chk_vld_s1;
	idx_t   idx_s1;
	entry_t rd_s1;

	// Result staging and output register
	hit_t    res_hit_q;
	status_t res_status_q;
	logic    out_vld_q;
	hit_t    out_hit_q;
	status_t out_status_q;

	logic   accept;
	logic   issue;
	logic   load_out;
	logic   wr_en;
	entry_t wr_data;
	entry_t cur;
	logic   cur_en;
	logic   ap_eq, client_eq, client_any, client_zero, ap_zero, date_ok;
	logic   term;
	hit_t   term_hit;
	status_t term_status;
	logic   last_entry;
	logic   do_insert;

	assign req.ready     = (state_q == S_IDLE);
	assign accept        = req.valid && req.ready;
	assign rsp.valid     = out_vld_q;
	assign rsp.hit_index = out_hit_q;
	assign rsp.status    = out_status_q;

	assign issue    = (state_q == S_SCAN) && (rd_idx_q < cnt_t'(TABLE_DEPTH));
	assign load_out = (state_q == S_RESULT) && (!out_vld_q || rsp.ready);
	assign wr_data  = '{client: dev_q, ap: ap_q, expiry: exp_q};

	// Entry memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_s1] <= wr_data;
		end
		if (issue) begin
			rd_s1 <= mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	// Entry evaluator: a never-written entry reads as all zero
	always_comb begin
		cur         = used_q[idx_s1] ? rd_s1 : '0;
		cur_en      = en_q[idx_s1];
		ap_eq       = (cur.ap == ap_q);
		client_eq   = (cur.client == dev_q);
		client_any  = (cur.client == MAC_ANY);
		client_zero = (cur.client == '0);
		ap_zero     = (cur.ap == '0);
		date_ok     = (today_q <= cur.expiry);
		last_entry  = (idx_s1 == idx_t'(TABLE_DEPTH - 1));
		term        = 1'b0;
		term_hit    = hit_t'(cnt_t'(idx_s1) + cnt_t'(1));
		term_status = ST_DONE;
		wr_en       = 1'b0;
		do_insert   = 1'b0;
		if (chk_vld_s1 && state_q == S_SCAN) begin
			case (cmd_q)
				CMD_ADD: begin
					if (cur_en && client_eq && ap_eq) begin
						term        = 1'b1;
						wr_en       = 1'b1;
						term_status = ST_UPDATED;
					end else if (!cur_en && client_zero && ap_zero) begin
						term        = 1'b1;
						wr_en       = 1'b1;
						do_insert   = 1'b1;
						term_status = ST_INSERTED;
					end
				end
				CMD_DEV_LOOKUP: begin
					if (!cur_en && client_zero) begin
						term     = 1'b1;
						term_hit = '0;
					end else if (cur_en && ap_eq && (client_any || client_eq) && date_ok) begin
						term = 1'b1;
					end
				end
				CMD_AP_LOOKUP: begin
					if (!cur_en && ap_zero) begin
						term     = 1'b1;
						term_hit = '0;
					end else if (cur_en && ap_eq) begin
						term = 1'b1;
					end
				end
				default: begin
					term = 1'b0;
				end
			endcase
			// Scan ran off the end without a decision
			if (!term && last_entry) begin
				term        = 1'b1;
				term_hit    = '0;
				term_status = (cmd_q == CMD_ADD) ? ST_FULL : ST_DONE;
			end
		end
	end

	// Sequencer, marks and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			en_q       <= '0;
			seen_q     <= '0;
			used_q     <= '0;
			rd_idx_q   <= '0;
			chk_vld_s1 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_idx_q     <= '0;
						chk_vld_s1   <= 1'b0;
						res_hit_q    <= '0;
						res_status_q <= ST_DONE;
						case (req.cmd)
							CMD_BEGIN_REFRESH: begin
								seen_q  <= '0;
								state_q <= S_RESULT;
							end
							CMD_END_REFRESH: begin
								en_q    <= en_q & seen_q;
								state_q <= S_RESULT;
							end
							CMD_ADD, CMD_DEV_LOOKUP, CMD_AP_LOOKUP: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_RESULT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (term) begin
						chk_vld_s1   <= 1'b0;
						res_hit_q    <= term_hit;
						res_status_q <= term_status;
						state_q      <= S_RESULT;
						if (wr_en) begin
							seen_q[idx_s1] <= 1'b1;
							used_q[idx_s1] <= 1'b1;
						end
						if (do_insert) begin
							en_q[idx_s1] <= 1'b1;
						end
					end else begin
						chk_vld_s1 <= issue;
						if (issue) begin
							idx_s1   <= rd_idx_q[IDX_W-1:0];
							rd_idx_q <= rd_idx_q + cnt_t'(1);
						end
					end
				end
				S_RESULT: begin
					if (load_out) begin
						out_hit_q    <= res_hit_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.cmd;
			ap_q    <= req.ap_mac;
			dev_q   <= req.device_mac;
			exp_q   <= req.expiry_date;
			today_q <= req.today;
		end
	end

	// A full table reports no index
	a_full_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.hit_index == '0)
		else $error("table full result carries an index");

	// Update and insert always name the written entry
	a_write_has_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_UPDATED || rsp.status == ST_INSERTED)
		|-> rsp.hit_index != '0)
		else $error("write result without an index");

	// The checked entry is always the one just before the read pointer
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (cnt_t'(idx_s1) + cnt_t'(1)) == rd_idx_q)
		else $error("scan pipeline out of step with read pointer");

	// An entry is never enabled without having been written
	a_enabled_written: assert property (@(posedge clk) disable iff (!arst_n)
		(en_q & ~used_q) == '0)
		else $error("enabled entry was never written");

endmodule
